### design/upv_pkg.sv
// upv_pkg: shared types and constants of the update package verifier.
// No dependencies; imported by the verdict channel interface, the top level and the verification files.
`default_nettype none

package upv_pkg;

  // Verdict codes carried on the result channel.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_TRUNCATED = 3'd2,
    STAT_BAD_MAGIC = 3'd3,
    STAT_BAD_VER   = 3'd4,
    STAT_NAME_LONG = 3'd5,
    STAT_MISMATCH  = 3'd6
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_idx_t;

  localparam logic [31:0] HASH_SEED     = 32'd7;
  localparam logic [31:0] MAGIC_DEFAULT = 32'h5055_4C54;  // first byte in bits 7..0
  localparam logic [7:0]  VER_DEFAULT   = 8'd1;

endpackage : upv_pkg

`default_nettype wire

### design/upv_ifs.sv
// upv_ifs: valid/ready channel interfaces for the byte input and the verdict output.
// Depends on upv_pkg (status_t).
`default_nettype none

interface upv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface : upv_in_if

interface upv_out_if
  import upv_pkg::*;
  ;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] computed_hash;
  logic [31:0] header_hash;
  logic [31:0] blocks_seen;

  modport source (output valid, status, computed_hash, header_hash, blocks_seen,
                  input ready);
  modport sink   (input valid, status, computed_hash, header_hash, blocks_seen,
                  output ready);
endinterface : upv_out_if

`default_nettype wire

### design/update_package_verifier.sv
// update_package_verifier: streaming byte parser and hash checker for update packages.
// Depends on upv_pkg and the channel interfaces in upv_ifs.sv.
`default_nettype none

// Channel    Dir  Word                                          Handshake
// ---------  ---  --------------------------------------------  ---------------
// in_word    in   data_byte[7:0], end_of_stream                 valid/ready
// out_word   out  status[2:0], computed_hash, header_hash,      valid/ready
//                 blocks_seen (32 bits each)
// cfg_*      in   cfg_we, cfg_index[0], cfg_wdata[31:0]         write on cfg_we
//
// One byte per cycle while the output register is not stalled. A byte lands in
// the input register, then the parse step (one fold hash*31+v as shift-subtract-add)
// updates the parse state and, on a verdict, loads the output register.
// Reset (sync, active low) clears both stages and restores the default magic
// and version. A stalled output register holds its word; the input stage keeps
// taking bytes until the input register is also full.

module update_package_verifier
  import upv_pkg::*;
#(
  parameter int MAX_NAME_LENGTH = 255
) (
  input  wire          clk,
  input  wire          rst_n,
  upv_in_if.sink       in_word,
  upv_out_if.source    out_word,
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire [31:0]   cfg_wdata
);

  typedef enum logic [9:0] {
    PH_MAGIC   = 10'b00_0000_0001,
    PH_VERSION = 10'b00_0000_0010,
    PH_HASH    = 10'b00_0000_0100,
    PH_COUNT   = 10'b00_0000_1000,
    PH_TYPE    = 10'b00_0001_0000,
    PH_NAMELEN = 10'b00_0010_0000,
    PH_NAME    = 10'b00_0100_0000,
    PH_SIZE    = 10'b00_1000_0000,
    PH_DATA    = 10'b01_0000_0000,
    PH_IDLE    = 10'b10_0000_0000
  } phase_t;

  // configuration
  logic [31:0] magic_r;
  logic [7:0]  version_r;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eos_r;

  // parse state
  phase_t      phase_r,   phase_nxt;
  logic [1:0]  idx_r,     idx_nxt;
  logic [31:0] acc_r,     acc_nxt;
  logic [31:0] hh_r,      hh_nxt;
  logic [31:0] total_r,   total_nxt;
  logic [31:0] done_r,    done_nxt;
  logic [31:0] hash_r,    hash_nxt;
  logic [31:0] rem_r,     rem_nxt;
  logic        verdict_r, verdict_nxt;
  logic [1:0]  fault_r,   fault_nxt;   // bit0 magic, bit1 version

  // output register
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_hash_r;
  logic [31:0] out_hh_r;
  logic [31:0] out_done_r;

  logic        advance;
  logic        step;
  logic        emit;
  status_t     emit_status;

  logic [31:0] acc_g;
  logic [31:0] fold_v;
  logic [31:0] hash_f;
  logic [31:0] done_inc;
  logic [31:0] rem_dec;

  assign advance      = !out_valid_r || out_word.ready;
  assign step         = s1_valid_r && advance;
  assign in_word.ready = !s1_valid_r || advance;

  assign out_word.valid         = out_valid_r;
  assign out_word.status        = out_status_r;
  assign out_word.computed_hash = out_hash_r;
  assign out_word.header_hash   = out_hh_r;
  assign out_word.blocks_seen   = out_done_r;

  // little-endian field gather and the single hash fold of this byte
  assign acc_g    = acc_r | (32'(s1_byte_r) << {idx_r, 3'b000});
  assign fold_v   = (phase_r == PH_NAMELEN || phase_r == PH_SIZE) ? acc_g : 32'(s1_byte_r);
  assign hash_f   = (hash_r << 5) - hash_r + fold_v;
  assign done_inc = done_r + 32'd1;
  assign rem_dec  = rem_r - 32'd1;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    hh_nxt      = hh_r;
    total_nxt   = total_r;
    done_nxt    = done_r;
    hash_nxt    = hash_r;
    rem_nxt     = rem_r;
    verdict_nxt = verdict_r;
    fault_nxt   = fault_r;
    emit        = 1'b0;
    emit_status = STAT_OK;

    if (!verdict_r) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            acc_nxt   = '0;
            fault_nxt = fault_r | {1'b0, acc_g != magic_r};
            phase_nxt = PH_VERSION;
          end else begin
            idx_nxt = idx_r + 2'd1;
            acc_nxt = acc_g;
          end
        end
        PH_VERSION: begin
          fault_nxt = fault_r | {s1_byte_r != version_r, 1'b0};
          phase_nxt = PH_HASH;
        end
        PH_HASH: begin
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            acc_nxt   = '0;
            hh_nxt    = acc_g;
            phase_nxt = PH_COUNT;
          end else begin
            idx_nxt = idx_r + 2'd1;
            acc_nxt = acc_g;
          end
        end
        PH_COUNT: begin
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            acc_nxt   = '0;
            total_nxt = acc_g;
            phase_nxt = PH_TYPE;
            priority if (fault_r[0]) begin
              emit = 1'b1; emit_status = STAT_BAD_MAGIC;
            end else if (fault_r[1]) begin
              emit = 1'b1; emit_status = STAT_BAD_VER;
            end else if (acc_g == '0) begin
              emit = 1'b1; emit_status = STAT_EMPTY;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
            acc_nxt = acc_g;
          end
        end
        PH_TYPE: begin
          hash_nxt  = hash_f;
          phase_nxt = PH_NAMELEN;
        end
        PH_NAMELEN: begin
          if (idx_r != 2'd0) begin
            idx_nxt = 2'd0;
            acc_nxt = '0;
            if (acc_g > 32'(MAX_NAME_LENGTH)) begin
              // length itself is not folded on this error
              emit        = 1'b1;
              emit_status = STAT_NAME_LONG;
            end else begin
              hash_nxt  = hash_f;
              rem_nxt   = acc_g;
              phase_nxt = (acc_g != '0) ? PH_NAME : PH_SIZE;
            end
          end else begin
            idx_nxt = 2'd1;
            acc_nxt = acc_g;
          end
        end
        PH_NAME: begin
          hash_nxt = hash_f;
          rem_nxt  = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          if (idx_r == 2'd3) begin
            idx_nxt  = 2'd0;
            acc_nxt  = '0;
            hash_nxt = hash_f;
            rem_nxt  = acc_g;
            if (acc_g == '0) begin
              // zero-size block ends here
              done_nxt  = done_inc;
              phase_nxt = PH_TYPE;
              if (done_inc == total_r) begin
                emit        = 1'b1;
                emit_status = (hash_f == hh_r) ? STAT_OK : STAT_MISMATCH;
              end
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
            acc_nxt = acc_g;
          end
        end
        PH_DATA: begin
          hash_nxt = hash_f;
          rem_nxt  = rem_dec;
          if (rem_dec == '0) begin
            done_nxt  = done_inc;
            phase_nxt = PH_TYPE;
            if (done_inc == total_r) begin
              emit        = 1'b1;
              emit_status = (hash_f == hh_r) ? STAT_OK : STAT_MISMATCH;
            end
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase

      // end of stream with no verdict yet: short header or truncated body
      if (!emit && s1_eos_r) begin
        emit        = 1'b1;
        emit_status = (phase_nxt == PH_MAGIC || phase_nxt == PH_VERSION ||
                       phase_nxt == PH_HASH  || phase_nxt == PH_COUNT)
                      ? STAT_EMPTY : STAT_TRUNCATED;
      end

      if (emit) begin
        verdict_nxt = 1'b1;
        phase_nxt   = PH_IDLE;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_DEFAULT;
      version_r <= VER_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAGIC:   magic_r   <= cfg_wdata;
        CFG_VERSION: version_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      s1_byte_r <= in_word.data_byte;
      s1_eos_r  <= in_word.end_of_stream;
    end
  end

  // parse state; end of stream restarts the package after the byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && s1_eos_r)) begin
      phase_r   <= PH_MAGIC;
      idx_r     <= '0;
      acc_r     <= '0;
      hh_r      <= '0;
      total_r   <= '0;
      done_r    <= '0;
      hash_r    <= HASH_SEED;
      rem_r     <= '0;
      verdict_r <= 1'b0;
      fault_r   <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      acc_r     <= acc_nxt;
      hh_r      <= hh_nxt;
      total_r   <= total_nxt;
      done_r    <= done_nxt;
      hash_r    <= hash_nxt;
      rem_r     <= rem_nxt;
      verdict_r <= verdict_nxt;
      fault_r   <= fault_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_status_r <= emit_status;
      out_hash_r   <= hash_nxt;
      out_hh_r     <= hh_nxt;
      out_done_r   <= done_nxt;
    end
  end

endmodule : update_package_verifier

`default_nettype wire

### verif/upv_verdict_checker.sv
`timescale 1ns / 100ps
// upv_verdict_checker: watches the byte and verdict channels of update_package_verifier,
// predicts each verdict word from the accepted bytes and compares it field by field.
// Depends on upv_pkg (status_t, cfg_idx_t, defaults) and the channel interfaces in upv_ifs.sv.

module upv_verdict_checker
  import upv_pkg::*;
#(
  parameter int MAX_NAME_LENGTH = 255
) (
  input  wire         clk,
  input  wire         rst_n,
  upv_in_if           in_mon,
  upv_out_if          out_mon,
  input  wire         cfg_we,
  input  cfg_idx_t    cfg_index,
  input  wire  [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef enum logic [3:0] {
    SCAN_MAGIC, SCAN_VERSION, SCAN_HASH, SCAN_COUNT, SCAN_TYPE,
    SCAN_NAMELEN, SCAN_NAME, SCAN_SIZE, SCAN_DATA, SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] computed_hash;
    logic [31:0] header_hash;
    logic [31:0] blocks_seen;
  } verdict_t;

  // Register copies.
  logic [31:0] magic_cfg;
  logic [7:0]  ver_cfg;

  // Package scan state.
  scan_phase_t phase;
  logic [1:0]  field_idx;
  logic [31:0] field_acc;
  logic [31:0] hdr_hash;
  logic [31:0] blk_total;
  logic [31:0] blk_done;
  logic [31:0] run_hash;
  logic [31:0] remaining;
  bit          verdict_out;
  bit          magic_bad;
  bit          ver_bad;

  verdict_t verdict_q[$];
  verdict_t verdict_word;
  bit       verdict_ready;
  int       fails = 0;
  int       n_checked = 0;

  function automatic void restart_scan();
    phase       = SCAN_MAGIC;
    field_idx   = '0;
    field_acc   = '0;
    hdr_hash    = '0;
    blk_total   = '0;
    blk_done    = '0;
    run_hash    = HASH_SEED;
    remaining   = '0;
    verdict_out = 1'b0;
    magic_bad   = 1'b0;
    ver_bad     = 1'b0;
  endfunction

  function automatic void mix(logic [31:0] v);
    run_hash = run_hash * 32'd31 + v;
  endfunction

  // Little-endian field assembly; returns 1 on the last byte of the field.
  function automatic bit take_field(logic [7:0] b, int len);
    field_acc |= {24'd0, b} << (8 * field_idx);
    if (int'(field_idx) + 1 >= len) begin
      field_idx = '0;
      return 1'b1;
    end
    field_idx = field_idx + 2'd1;
    return 1'b0;
  endfunction

  function automatic void give_verdict(status_t s);
    verdict_word.status        = s;
    verdict_word.computed_hash = run_hash;
    verdict_word.header_hash   = hdr_hash;
    verdict_word.blocks_seen   = blk_done;
    verdict_ready = 1'b1;
    verdict_out   = 1'b1;
    phase         = SCAN_DONE;
  endfunction

  function automatic void close_block();
    blk_done = blk_done + 32'd1;
    if (blk_done == blk_total)
      give_verdict((run_hash == hdr_hash) ? STAT_OK : STAT_MISMATCH);
    else
      phase = SCAN_TYPE;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic [31:0] v;
    case (phase)
      SCAN_MAGIC: begin
        if (take_field(b, 4)) begin
          if (field_acc != magic_cfg) magic_bad = 1'b1;
          field_acc = '0;
          phase = SCAN_VERSION;
        end
      end
      SCAN_VERSION: begin
        if (b != ver_cfg) ver_bad = 1'b1;
        phase = SCAN_HASH;
      end
      SCAN_HASH: begin
        if (take_field(b, 4)) begin
          hdr_hash  = field_acc;
          field_acc = '0;
          phase = SCAN_COUNT;
        end
      end
      SCAN_COUNT: begin
        if (take_field(b, 4)) begin
          blk_total = field_acc;
          field_acc = '0;
          // header faults are ranked magic, version, then empty count
          if (magic_bad)           give_verdict(STAT_BAD_MAGIC);
          else if (ver_bad)        give_verdict(STAT_BAD_VER);
          else if (blk_total == 0) give_verdict(STAT_EMPTY);
          else                     phase = SCAN_TYPE;
        end
      end
      SCAN_TYPE: begin
        mix({24'd0, b});
        phase = SCAN_NAMELEN;
      end
      SCAN_NAMELEN: begin
        if (take_field(b, 2)) begin
          v = field_acc;
          field_acc = '0;
          if (v > MAX_NAME_LENGTH) begin
            give_verdict(STAT_NAME_LONG);
          end else begin
            mix(v);
            remaining = v;
            phase = (v != 0) ? SCAN_NAME : SCAN_SIZE;
          end
        end
      end
      SCAN_NAME: begin
        mix({24'd0, b});
        remaining = remaining - 32'd1;
        if (remaining == 0) phase = SCAN_SIZE;
      end
      SCAN_SIZE: begin
        if (take_field(b, 4)) begin
          v = field_acc;
          field_acc = '0;
          mix(v);
          remaining = v;
          if (v == 0) close_block();
          else        phase = SCAN_DATA;
        end
      end
      SCAN_DATA: begin
        mix({24'd0, b});
        remaining = remaining - 32'd1;
        if (remaining == 0) close_block();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eos);
    verdict_ready = 1'b0;
    if (!verdict_out) scan_byte(b);
    if (!verdict_out && eos)
      give_verdict((phase <= SCAN_COUNT) ? STAT_EMPTY : STAT_TRUNCATED);
    if (eos) restart_scan();
    if (verdict_ready) verdict_q.push_back(verdict_word);
  endfunction

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst_n) begin
      magic_cfg = MAGIC_DEFAULT;
      ver_cfg   = VER_DEFAULT;
      restart_scan();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict word with nothing expected: status %0d hash %h",
                 out_mon.status, out_mon.computed_hash);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fails++;
          end
          if (out_mon.computed_hash !== want.computed_hash) begin
            $error("computed_hash: expected %h, got %h",
                   want.computed_hash, out_mon.computed_hash);
            fails++;
          end
          if (out_mon.header_hash !== want.header_hash) begin
            $error("header_hash: expected %h, got %h",
                   want.header_hash, out_mon.header_hash);
            fails++;
          end
          if (out_mon.blocks_seen !== want.blocks_seen) begin
            $error("blocks_seen: expected %0d, got %0d",
                   want.blocks_seen, out_mon.blocks_seen);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:   magic_cfg = cfg_wdata;
          CFG_VERSION: ver_cfg   = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_byte(in_mon.data_byte, in_mon.end_of_stream);
    end
    fail_count <= fails;
    pending    <= verdict_q.size();
    checked    <= n_checked;
  end

endmodule : upv_verdict_checker

### verif/update_package_verifier_tb.sv
`timescale 1ns / 100ps
// update_package_verifier_tb: stimulus and verdict for the update package verifier.
// Depends on upv_pkg, upv_ifs.sv, the block itself and upv_verdict_checker.

module update_package_verifier_tb;
  import upv_pkg::*;

  localparam int NAME_MAX     = 255;
  localparam int PHASE_BYTES  = 480;   // random bytes per handshake mix
  localparam int DRAIN_CYCLES = 8;     // drain of the input and output registers plus margin
  localparam int HOLD_CYCLES  = 300;   // receiver hold-off under pressure
  localparam int BURST_PKTS   = 48;    // one-byte packages sent into the hold-off

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_wdata;

  upv_in_if  in_word();
  upv_out_if out_word();

  int fail_count;
  int pending;
  int checked;

  // Handshake mix knobs, in percent.
  int src_idle_pct;
  int sink_stall_pct;
  bit hold_req;

  int          bytes_sent;
  logic [31:0] cur_magic;
  logic [7:0]  cur_ver;
  logic [7:0]  pkt[$];    // package being sent
  logic [7:0]  body[$];   // block section, built before the header hash is known

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  update_package_verifier #(
    .MAX_NAME_LENGTH(NAME_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  upv_verdict_checker #(
    .MAX_NAME_LENGTH(NAME_MAX)
  ) verdict_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_word),
    .out_mon   (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // Receiver: random stalls per the current mix; a hold request parks ready
  // low for a long stretch so the block backs up onto its input.
  initial begin
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_word.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_word.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("update_package_verifier_tb: FAIL");
    $finish;
  end

  // Offer one byte, with random idle cycles ahead of it; returns on acceptance.
  // valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(logic [7:0] b, logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid         <= 1'b1;
    in_word.data_byte     <= b;
    in_word.end_of_stream <= eos;
    do @(posedge clk); while (!in_word.ready);
    bytes_sent++;
  endtask

  // end_of_stream rides on the last byte of every package.
  task automatic send_package();
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
  endtask

  // Quiet point: nothing owed on the verdict side, then let the pipeline empty
  // of bytes that produce no verdict. One edge first so the owed count
  // includes the byte accepted on the edge we were called at.
  task automatic wait_idle();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers, on consecutive edges, only from a quiet point.
  task automatic write_regs(logic [31:0] magic, logic [7:0] ver);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_wdata <= {24'd0, ver};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_magic = magic;
    cur_ver   = ver;
  endtask

  function automatic void push32(logic [31:0] v);
    for (int i = 0; i < 4; i++) pkt.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_header(logic [31:0] magic, logic [7:0] ver,
                                      logic [31:0] hh, logic [31:0] count);
    push32(magic);
    pkt.push_back(ver);
    push32(hh);
    push32(count);
  endfunction

  function automatic logic [31:0] hash_step(logic [31:0] h, logic [31:0] v);
    return h * 32'd31 + v;
  endfunction

  // Appends one block to body and returns the running hash after it. An
  // overlong name stops right after the length field.
  function automatic logic [31:0] add_block(logic [31:0] h, bit long_name);
    logic [7:0]  typ, b;
    logic [31:0] nl, sz;
    int          r;
    typ = 8'($urandom);
    body.push_back(typ);
    h = hash_step(h, {24'd0, typ});
    r = $urandom_range(99);
    if (long_name)   nl = $urandom_range(65535, NAME_MAX + 1);
    else if (r < 88) nl = $urandom_range(6, 0);
    else if (r < 94) nl = $urandom_range(40, 7);
    else             nl = $urandom_range(NAME_MAX, 200);
    body.push_back(nl[7:0]);
    body.push_back(nl[15:8]);
    if (long_name) return h;
    h = hash_step(h, nl);
    repeat (nl) begin
      b = 8'($urandom);
      body.push_back(b);
      h = hash_step(h, {24'd0, b});
    end
    sz = ($urandom_range(99) < 85) ? $urandom_range(8, 0) : $urandom_range(48, 9);
    for (int i = 0; i < 4; i++) body.push_back(sz[8*i +: 8]);
    h = hash_step(h, sz);
    repeat (sz) begin
      b = 8'($urandom);
      body.push_back(b);
      h = hash_step(h, {24'd0, b});
    end
    return h;
  endfunction

  // One random package. Mostly well formed (half with a matching header hash,
  // some with trailing bytes past the last block); the rest are cut short,
  // carry a wrong magic or version, a zero block count, an overlong name, or
  // are plain noise.
  task automatic build_package();
    int          r, nblk, long_at;
    int unsigned cut;
    logic [31:0] h, magic, hh, count;
    logic [7:0]  ver;
    pkt.delete();
    body.delete();
    r = $urandom_range(99);
    if (r >= 92) begin
      repeat ($urandom_range(20, 1)) pkt.push_back(8'($urandom));
      return;
    end
    nblk    = ($urandom_range(99) < 80) ? $urandom_range(2, 1) : $urandom_range(5, 3);
    long_at = (r >= 86) ? $urandom_range(nblk - 1, 0) : -1;
    h = HASH_SEED;
    for (int k = 0; k < nblk; k++) begin
      h = add_block(h, k == long_at);
      if (k == long_at) break;
    end
    magic = cur_magic;
    ver   = cur_ver;
    count = nblk;
    hh    = $urandom_range(1) ? h : $urandom;
    if (r >= 68 && r < 74) begin
      magic ^= 32'd1 << $urandom_range(31, 0);
      if ($urandom_range(3) == 0) ver ^= 8'hFF;   // both faults: magic must win
    end else if (r >= 74 && r < 80) begin
      ver ^= 8'd1 << $urandom_range(7, 0);
    end else if (r >= 80 && r < 86) begin
      count = '0;
    end else if (r >= 60 && r < 68 && $urandom_range(1)) begin
      count = $urandom;
    end
    push_header(magic, ver, hh, count);
    foreach (body[i]) pkt.push_back(body[i]);
    if (r >= 60 && r < 68) begin
      // truncation anywhere, header included
      cut = $urandom_range(pkt.size() - 1, 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end else if ((r < 60 || r >= 86) && $urandom_range(99) < 30) begin
      repeat ($urandom_range(3, 1)) pkt.push_back(8'($urandom));
    end
  endtask

  initial begin
    int phase_start;
    in_word.valid         <= 1'b0;
    in_word.data_byte     <= '0;
    in_word.end_of_stream <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_MAGIC;
    cfg_wdata             <= '0;
    rst_n                 <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    bytes_sent     = 0;
    cur_magic      = MAGIC_DEFAULT;
    cur_ver        = VER_DEFAULT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: header cut short on its first byte (all ones, then all zeros),
    // then an overlong name whose length byte also ends the stream.
    pkt.delete();
    pkt.push_back(8'hFF);
    send_package();
    pkt.delete();
    pkt.push_back(8'h00);
    send_package();
    pkt.delete();
    push_header(MAGIC_DEFAULT, VER_DEFAULT, 32'hFFFF_FFFF, 32'd2);
    pkt.push_back(8'h80);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);    // length 256
    send_package();
    wait_idle();

    // Pressure: receiver parked while one-byte packages keep coming, each one
    // a verdict, so the output and then the input register fill.
    hold_req = 1'b1;
    repeat (BURST_PKTS) send_word(8'($urandom), 1'b1);
    wait_idle();

    // Random packages under four handshake mixes and four register settings.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_regs(MAGIC_DEFAULT, VER_DEFAULT);
          src_idle_pct = 0;  sink_stall_pct = 0;
        end
        1: begin
          write_regs(32'hFFFF_FFFF, 8'hFF);
          src_idle_pct = 77; sink_stall_pct = 0;
        end
        2: begin
          write_regs(32'h0000_0000, 8'h00);
          src_idle_pct = 0;  sink_stall_pct = 77;
        end
        default: begin
          write_regs($urandom, 8'($urandom));
          src_idle_pct = 33; sink_stall_pct = 33;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_package();
        send_package();
      end
      wait_idle();
    end

    $display("update_package_verifier_tb: %0d bytes streamed, %0d verdict words checked",
             bytes_sent, checked);
    $display("update_package_verifier_tb: four idle/stall mixes, a long output hold-off, "
             , "default and extreme magic/version settings");
    if (fail_count == 0)
      $display("update_package_verifier_tb: PASS");
    else
      $display("update_package_verifier_tb: FAIL");
    $finish;
  end

endmodule : update_package_verifier_tb
